### rtl/pvd_pkg.sv
// ----------------------------------------------------------------------------
// pvd_pkg
// Shared types, widths and helpers for the plane volume distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package pvd_pkg;

  localparam int FRAC_BITS = 16;

  // floor(a*b / 2^F) of two signed 32-bit values
  localparam int PROD_W = 64 - FRAC_BITS;
  // (|n| * h) >> F, |n| <= 2^31, h < 2^31
  localparam int EXT_W  = 63 - FRAC_BITS;
  // d and e, exact
  localparam int SUM_W  = PROD_W + 2;
  // d - e and d + e, exact
  localparam int DIFF_W = SUM_W + 1;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X     = 2'd0,
    REG_NORMAL_Y     = 2'd1,
    REG_NORMAL_Z     = 2'd2,
    REG_PLANE_OFFSET = 2'd3
  } pvd_reg_e;

  typedef struct packed {
    logic              is_box;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]       extent_x;
    logic [30:0]       extent_y;
    logic [30:0]       extent_z;
  } pvd_in_t;

  typedef struct packed {
    logic signed [31:0] min_distance;
    logic signed [31:0] max_distance;
    logic              crosses_plane;
  } pvd_out_t;

  // plane registers plus normal magnitudes formed at write time
  typedef struct packed {
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] plane_offset;
    logic [31:0]       mag_x;
    logic [31:0]       mag_y;
    logic [31:0]       mag_z;
  } pvd_plane_t;

  typedef struct packed {
    logic                   is_box;
    logic signed [PROD_W-1:0] p_x;
    logic signed [PROD_W-1:0] p_y;
    logic signed [PROD_W-1:0] p_z;
    logic [EXT_W-1:0]       q_x;
    logic [EXT_W-1:0]       q_y;
    logic [EXT_W-1:0]       q_z;
    logic [30:0]            radius;
  } pvd_prod_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] center_dist;
    logic [SUM_W-1:0]        ext;
  } pvd_sum_t;

  function automatic logic signed [31:0] sat32(input logic signed [DIFF_W-1:0] v);
    logic fits;
    fits = (&v[DIFF_W-1:31]) || !(|v[DIFF_W-1:31]);
    if (fits) begin
      sat32 = v[31:0];
    end else if (v[DIFF_W-1]) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = 32'sh7fff_ffff;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/plane_volume_distance.sv
// ----------------------------------------------------------------------------
// plane_volume_distance
// Signed distance of a sphere or axis-aligned box against a configured plane.
// ----------------------------------------------------------------------------
// Takes one volume beat per cycle while not backed up and returns one
// result beat per volume, in order, valid at the port once the beat has
// passed the multiply, pair, sum, bound and output registers. The depth is
// set by the multiply stage (six products in parallel) and four
// adder/saturation stages behind it. Each stage carries its own valid bit
// and holds only when the stage after it is full, so bubbles are
// squeezed out and input keeps flowing while a result waits at the output.
// Write the plane registers only while no beat is in flight; the config
// port is always ready and an index beyond the register list is ignored
// by construction of the two-bit index.
`default_nettype none

module plane_volume_distance (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire pvd_pkg::pvd_in_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output pvd_pkg::pvd_out_t                  out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pvd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i
);

  pvd_pkg::pvd_plane_t plane;
  pvd_pkg::pvd_prod_t  prod;
  pvd_pkg::pvd_sum_t   sum;
  logic                prod_valid, prod_ready;
  logic                sum_valid, sum_ready;

  pvd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .plane_o     (plane)
  );

  pvd_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .plane_i (plane),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .data_o  (prod)
  );

  pvd_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .data_i  (prod),
    .plane_i (plane),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .data_o  (sum)
  );

  pvd_res u_res (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .data_i  (sum),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### rtl/pvd_cfg.sv
// ----------------------------------------------------------------------------
// pvd_cfg
// Plane register file; keeps normal magnitudes alongside the normal.
// ----------------------------------------------------------------------------
`default_nettype none

module pvd_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pvd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i,
  output pvd_pkg::pvd_plane_t                plane_o
);

  pvd_pkg::pvd_plane_t plane_q, plane_d;
  logic [31:0]         mag;

  assign cfg_ready_o = 1'b1;
  assign mag = cfg_data_i[31] ? (~cfg_data_i + 32'd1) : cfg_data_i;

  always_comb begin
    plane_d = plane_q;
    if (cfg_valid_i) begin
      case (pvd_pkg::pvd_reg_e'(cfg_index_i))
        pvd_pkg::REG_NORMAL_X: begin
          plane_d.normal_x = cfg_data_i;
          plane_d.mag_x    = mag;
        end
        pvd_pkg::REG_NORMAL_Y: begin
          plane_d.normal_y = cfg_data_i;
          plane_d.mag_y    = mag;
        end
        pvd_pkg::REG_NORMAL_Z: begin
          plane_d.normal_z = cfg_data_i;
          plane_d.mag_z    = mag;
        end
        pvd_pkg::REG_PLANE_OFFSET: begin
          plane_d.plane_offset = cfg_data_i;
        end
        default: begin
          plane_d = plane_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else begin
      plane_q <= plane_d;
    end
  end

  assign plane_o = plane_q;

endmodule

`default_nettype wire

### rtl/pvd_prod.sv
// ----------------------------------------------------------------------------
// pvd_prod
// Multiply stage: dot product terms and box extent terms, one register.
// ----------------------------------------------------------------------------
`default_nettype none

module pvd_prod (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire pvd_pkg::pvd_in_t    data_i,
  input  wire pvd_pkg::pvd_plane_t plane_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output pvd_pkg::pvd_prod_t       data_o
);

  logic                      en;
  logic                      valid_q;
  pvd_pkg::pvd_prod_t        prod_q, prod_d;
  logic signed [63:0]        full_x, full_y, full_z;
  logic [62:0]               ext_x, ext_y, ext_z;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  // signed product then arithmetic shift: floor toward minus infinity
  assign full_x = plane_i.normal_x * data_i.center_x;
  assign full_y = plane_i.normal_y * data_i.center_y;
  assign full_z = plane_i.normal_z * data_i.center_z;

  assign ext_x = {31'd0, plane_i.mag_x} * {32'd0, data_i.extent_x};
  assign ext_y = {31'd0, plane_i.mag_y} * {32'd0, data_i.extent_y};
  assign ext_z = {31'd0, plane_i.mag_z} * {32'd0, data_i.extent_z};

  always_comb begin
    prod_d.is_box = data_i.is_box;
    prod_d.p_x    = full_x[63:pvd_pkg::FRAC_BITS];
    prod_d.p_y    = full_y[63:pvd_pkg::FRAC_BITS];
    prod_d.p_z    = full_z[63:pvd_pkg::FRAC_BITS];
    prod_d.q_x    = ext_x[62:pvd_pkg::FRAC_BITS];
    prod_d.q_y    = ext_y[62:pvd_pkg::FRAC_BITS];
    prod_d.q_z    = ext_z[62:pvd_pkg::FRAC_BITS];
    prod_d.radius = data_i.extent_x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = prod_q;

endmodule

`default_nettype wire

### rtl/pvd_sum.sv
// ----------------------------------------------------------------------------
// pvd_sum
// Two adder stages: pair sums, then center distance and projected extent.
// ----------------------------------------------------------------------------
`default_nettype none

module pvd_sum (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire pvd_pkg::pvd_prod_t  data_i,
  input  wire pvd_pkg::pvd_plane_t plane_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output pvd_pkg::pvd_sum_t        data_o
);

  localparam int PW = pvd_pkg::PROD_W;
  localparam int EW = pvd_pkg::EXT_W;
  localparam int SW = pvd_pkg::SUM_W;

  typedef struct packed {
    logic signed [PW:0] s_xy;
    logic signed [PW:0] s_zo;
    logic [EW:0]        e_xy;
    logic [EW:0]        e_z;
  } pair_t;

  logic              en_a, en_b;
  logic              valid_a_q, valid_b_q;
  pair_t             pair_q, pair_d;
  pvd_pkg::pvd_sum_t sum_q, sum_d;

  assign en_b    = !valid_b_q || ready_i;
  assign en_a    = !valid_a_q || en_b;
  assign ready_o = en_a;

  always_comb begin
    pair_d.s_xy = {data_i.p_x[PW-1], data_i.p_x} + {data_i.p_y[PW-1], data_i.p_y};
    pair_d.s_zo = {data_i.p_z[PW-1], data_i.p_z}
                + {{(PW + 1 - 32){plane_i.plane_offset[31]}}, plane_i.plane_offset};
    if (data_i.is_box) begin
      pair_d.e_xy = {1'b0, data_i.q_x} + {1'b0, data_i.q_y};
      pair_d.e_z  = {1'b0, data_i.q_z};
    end else begin
      pair_d.e_xy = '0;
      pair_d.e_z  = {{(EW + 1 - 31){1'b0}}, data_i.radius};
    end
  end

  always_comb begin
    sum_d.center_dist = {pair_q.s_xy[PW], pair_q.s_xy} + {pair_q.s_zo[PW], pair_q.s_zo};
    sum_d.ext  = {{(SW - EW - 1){1'b0}}, pair_q.e_xy} + {{(SW - EW - 1){1'b0}}, pair_q.e_z};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (en_a) begin
        valid_a_q <= valid_i;
      end
      if (en_b) begin
        valid_b_q <= valid_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && valid_i) begin
      pair_q <= pair_d;
    end
    if (en_b && valid_a_q) begin
      sum_q <= sum_d;
    end
  end

  assign valid_o = valid_b_q;
  assign data_o  = sum_q;

endmodule

`default_nettype wire

### rtl/pvd_res.sv
// ----------------------------------------------------------------------------
// pvd_res
// Result stages: bounds and |d|, then saturation and crossing test.
// ----------------------------------------------------------------------------
`default_nettype none

module pvd_res (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire pvd_pkg::pvd_sum_t  data_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output pvd_pkg::pvd_out_t       data_o
);

  localparam int SW = pvd_pkg::SUM_W;
  localparam int DW = pvd_pkg::DIFF_W;

  typedef struct packed {
    logic signed [DW-1:0] lo;
    logic signed [DW-1:0] hi;
    logic [SW-1:0]        abs_d;
    logic [SW-1:0]        ext;
  } bound_t;

  logic                 en_a, en_b;
  logic                 valid_a_q, valid_b_q;
  bound_t               bound_q, bound_d;
  pvd_pkg::pvd_out_t    out_q, out_d;
  logic signed [DW-1:0] d_ext, e_ext;

  assign en_b    = !valid_b_q || ready_i;
  assign en_a    = !valid_a_q || en_b;
  assign ready_o = en_a;

  assign d_ext = {data_i.center_dist[SW-1], data_i.center_dist};
  assign e_ext = {1'b0, data_i.ext};

  always_comb begin
    bound_d.lo    = d_ext - e_ext;
    bound_d.hi    = d_ext + e_ext;
    bound_d.abs_d = data_i.center_dist[SW-1] ? (~data_i.center_dist + SW'(1))
                                             : data_i.center_dist;
    bound_d.ext   = data_i.ext;
  end

  always_comb begin
    out_d.min_distance  = pvd_pkg::sat32(bound_q.lo);
    out_d.max_distance  = pvd_pkg::sat32(bound_q.hi);
    out_d.crosses_plane = bound_q.abs_d < bound_q.ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (en_a) begin
        valid_a_q <= valid_i;
      end
      if (en_b) begin
        valid_b_q <= valid_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && valid_i) begin
      bound_q <= bound_d;
    end
    if (en_b && valid_a_q) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_b_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

### rtl/pvd_chk.sv
// ----------------------------------------------------------------------------
// pvd_chk
// Port-level checks for plane_volume_distance, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pvd_chk (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_ready_o,
  input  wire logic              out_valid_o,
  input  wire logic              out_ready_i,
  input  wire pvd_pkg::pvd_out_t out_data_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // input only backs up when every stage is full and the output stalls
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  // extent is never negative
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.min_distance <= out_data_o.max_distance)
    else $error("min distance above max distance");

  // a crossing volume straddles the plane
  a_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.crosses_plane
      |-> out_data_o.min_distance < 0 && out_data_o.max_distance > 0)
    else $error("crossing flag without straddling bounds");

endmodule

bind plane_volume_distance pvd_chk u_pvd_chk (.*);

`default_nettype wire
